@@ hdl/cie94_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cie94_pkg
// Shared widths, weighting constants and types of the CIE94 difference block.
// ----------------------------------------------------------------------------
package cie94_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int CHROMA_EXTRA  = 16;

    localparam int L_W   = 15;  // lightness field
    localparam int LAB_W = 16;  // a / b fields
    localparam int OUT_W = 16;  // delta_e field
    localparam int CH_W  = 32;  // chroma, CHROMA_EXTRA more fraction bits
    localparam int RAD_W = 64;  // chroma radicand
    localparam int K_W   = 12;  // k1 / k2 in Q.16
    localparam int WT_W  = 25;  // SC / SH in Q.16
    localparam int NUM_W = 64;  // divider numerator
    localparam int QUO_W = 48;  // divider quotient
    localparam int SUM_W = 38;  // sum under the final root

    localparam logic [K_W-1:0] K1_GRAPHIC = 12'd2949;
    localparam logic [K_W-1:0] K2_GRAPHIC = 12'd983;
    localparam logic [K_W-1:0] K1_TEXTILE = 12'd3146;
    localparam logic [K_W-1:0] K2_TEXTILE = 12'd918;
    localparam logic [WT_W-1:0] WEIGHT_ONE = 25'd65536;

    typedef enum logic {
        MODE_GRAPHIC = 1'b0,
        MODE_TEXTILE = 1'b1
    } app_mode_t;

endpackage
`default_nettype wire

@@ hdl/cie94_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cie94 channel interfaces
// Pixel pair input, difference result output and mode write channel.
// ----------------------------------------------------------------------------
interface cie94_pair_if;
    import cie94_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [L_W-1:0]          first_l;
    logic signed [LAB_W-1:0] first_a;
    logic signed [LAB_W-1:0] first_b;
    logic [L_W-1:0]          second_l;
    logic signed [LAB_W-1:0] second_a;
    logic signed [LAB_W-1:0] second_b;
    modport source (output valid, first_l, first_a, first_b, second_l, second_a, second_b,
                    input ready);
    modport sink   (input valid, first_l, first_a, first_b, second_l, second_a, second_b,
                    output ready);
endinterface

interface cie94_result_if;
    import cie94_pkg::*;
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] delta_e;
    logic             saturated;
    modport source (output valid, delta_e, saturated, input ready);
    modport sink   (input valid, delta_e, saturated, output ready);
endinterface

interface cie94_cfg_if;
    logic valid;
    logic ready;
    logic app_mode;
    modport source (output valid, app_mode, input ready);
    modport sink   (input valid, app_mode, output ready);
endinterface
`default_nettype wire

@@ hdl/cie94_sqrt_pipe.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cie94_sqrt_pipe
// Pipelined restoring integer square root, one root bit per stage, lanes in
// parallel; returns floor root and remainder.
// ----------------------------------------------------------------------------
module cie94_sqrt_pipe #(
    parameter int W     = 64,
    parameter int LANES = 1,
    parameter int PW    = 1
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic [LANES-1:0][W-1:0]     in_rad,
    input  wire logic [PW-1:0]               in_pay,
    output logic                             out_valid,
    output logic [LANES-1:0][W/2-1:0]        out_root,
    output logic [LANES-1:0][W/2:0]          out_rem,
    output logic [PW-1:0]                    out_pay
);
    localparam int RW = W / 2;

    logic [LANES-1:0][W-1:0]  rem_reg  [RW];
    logic [LANES-1:0][RW-1:0] root_reg [RW];
    logic                     vld_reg  [RW];
    logic [PW-1:0]            pay_reg  [RW];

    for (genvar s = 0; s < RW; s++) begin : g_st
        localparam int K = RW - 1 - s;
        logic [LANES-1:0][W-1:0]  rem_in, rem_next;
        logic [LANES-1:0][RW-1:0] root_in, root_next;
        logic [LANES-1:0][W:0]    trial;
        logic [LANES-1:0]         take;
        logic                     v_in;
        logic [PW-1:0]            p_in;

        if (s == 0) begin : g_head
            assign rem_in  = in_rad;
            assign root_in = '0;
            assign v_in    = in_valid;
            assign p_in    = in_pay;
        end else begin : g_body
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign v_in    = vld_reg[s-1];
            assign p_in    = pay_reg[s-1];
        end

        // (r + 2^K)^2 - r^2 = r*2^(K+1) + 2^(2K)
        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                trial[l]     = ((W+1)'(root_in[l]) << (K + 1)) | ((W+1)'(1) << (2 * K));
                take[l]      = ({1'b0, rem_in[l]} >= trial[l]);
                rem_next[l]  = take[l] ? rem_in[l] - trial[l][W-1:0] : rem_in[l];
                root_next[l] = take[l] ? (root_in[l] | (RW'(1) << K)) : root_in[l];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (en)
                vld_reg[s] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
                pay_reg[s]  <= p_in;
            end
        end
    end

    assign out_valid = vld_reg[RW-1];
    assign out_root  = root_reg[RW-1];
    assign out_pay   = pay_reg[RW-1];

    // remainder is at most twice the root
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            out_rem[l] = rem_reg[RW-1][l][RW:0];
    end

endmodule
`default_nettype wire

@@ hdl/cie94_div_pipe.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cie94_div_pipe
// Pipelined restoring divider, one quotient bit per stage, lanes in parallel.
// Quotient must fit in Q bits.
// ----------------------------------------------------------------------------
module cie94_div_pipe #(
    parameter int NW    = 64,
    parameter int DW    = 25,
    parameter int Q     = 48,
    parameter int LANES = 2,
    parameter int PW    = 1
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     en,
    input  wire logic                     in_valid,
    input  wire logic [LANES-1:0][NW-1:0] in_num,
    input  wire logic [LANES-1:0][DW-1:0] in_den,
    input  wire logic [PW-1:0]            in_pay,
    output logic                          out_valid,
    output logic [LANES-1:0][Q-1:0]       out_quo,
    output logic [LANES-1:0][DW-1:0]      out_den,
    output logic [PW-1:0]                 out_pay
);
    localparam int XW = NW + Q;

    logic [LANES-1:0][NW-1:0] rem_reg [Q];
    logic [LANES-1:0][DW-1:0] den_reg [Q];
    logic [LANES-1:0][Q-1:0]  quo_reg [Q];
    logic                     vld_reg [Q];
    logic [PW-1:0]            pay_reg [Q];

    for (genvar s = 0; s < Q; s++) begin : g_st
        localparam int K = Q - 1 - s;
        logic [LANES-1:0][NW-1:0] rem_in, rem_next;
        logic [LANES-1:0][DW-1:0] den_in;
        logic [LANES-1:0][Q-1:0]  quo_in, quo_next;
        logic [LANES-1:0][XW-1:0] shd;
        logic [LANES-1:0]         take;
        logic                     v_in;
        logic [PW-1:0]            p_in;

        if (s == 0) begin : g_head
            assign rem_in = in_num;
            assign den_in = in_den;
            assign quo_in = '0;
            assign v_in   = in_valid;
            assign p_in   = in_pay;
        end else begin : g_body
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign quo_in = quo_reg[s-1];
            assign v_in   = vld_reg[s-1];
            assign p_in   = pay_reg[s-1];
        end

        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                shd[l]      = XW'(den_in[l]) << K;
                take[l]     = (XW'(rem_in[l]) >= shd[l]);
                rem_next[l] = take[l] ? rem_in[l] - shd[l][NW-1:0] : rem_in[l];
                quo_next[l] = take[l] ? (quo_in[l] | (Q'(1) << K)) : quo_in[l];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (en)
                vld_reg[s] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= rem_next;
                den_reg[s] <= den_in;
                quo_reg[s] <= quo_next;
                pay_reg[s] <= p_in;
            end
        end
    end

    assign out_valid = vld_reg[Q-1];
    assign out_quo   = quo_reg[Q-1];
    assign out_den   = den_reg[Q-1];
    assign out_pay   = pay_reg[Q-1];

endmodule
`default_nettype wire

@@ hdl/cie94_color_difference.sv @@
`default_nettype none
// Throughput: one pair per cycle; the whole pipeline advances together and
// holds when the result waits on a full output register.
// Reset: rst_n clears all valid bits and sets the mode to graphic arts.
// Pipeline depth is set by the bit-serial units: chroma root 32, two dividers 48 each,
// final root 19, plus 7 arithmetic and output stages.
// ----------------------------------------------------------------------------
// cie94_color_difference
// CIE94 color difference of two Lab colors, fully pipelined.
// ----------------------------------------------------------------------------
module cie94_color_difference #(
    parameter int FRAC_BITS = cie94_pkg::FRAC_BITS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    cie94_pair_if.sink    pair,
    cie94_result_if.source result,
    cie94_cfg_if.sink     cfg
);
    import cie94_pkg::*;

    // Global advance: the pipe moves unless a finished result is being held.
    logic en;
    logic out_vld_reg;
    assign en         = !out_vld_reg || result.ready;
    assign pair.ready = en;

    // Mode register; the user must let writes arrive only while idle, which the block does not enforce.
    app_mode_t mode_reg;
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_GRAPHIC;
        else if (cfg.valid)
            mode_reg <= app_mode_t'(cfg.app_mode);
    end

    // ---- Stage A: differences ----
    logic                    a_vld_reg;
    app_mode_t               a_mode_reg;
    logic signed [LAB_W-1:0] a_a1_reg, a_b1_reg, a_a2_reg, a_b2_reg;
    logic signed [LAB_W-1:0] a_dl_reg;
    logic signed [LAB_W:0]   a_da_reg, a_db_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (en)
            a_vld_reg <= pair.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_mode_reg <= mode_reg;
            a_a1_reg   <= pair.first_a;
            a_b1_reg   <= pair.first_b;
            a_a2_reg   <= pair.second_a;
            a_b2_reg   <= pair.second_b;
            a_dl_reg   <= LAB_W'(signed'({1'b0, pair.first_l}) - signed'({1'b0, pair.second_l}));
            a_da_reg   <= (LAB_W+1)'(pair.first_a) - (LAB_W+1)'(pair.second_a);
            a_db_reg   <= (LAB_W+1)'(pair.first_b) - (LAB_W+1)'(pair.second_b);
        end
    end

    // ---- Stage B: squares ----
    logic              b_vld_reg;
    app_mode_t         b_mode_reg;
    logic [31:0]       b_sq1_reg, b_sq2_reg, b_tl_reg;
    logic [33:0]       b_dab_reg;
    logic signed [31:0] xa1, xb1, xa2, xb2, xdl, tl_full;
    logic signed [33:0] xda, xdb;
    logic [31:0]       b_tl_next;

    always_comb
    begin
        xa1 = 32'(a_a1_reg);
        xb1 = 32'(a_b1_reg);
        xa2 = 32'(a_a2_reg);
        xb2 = 32'(a_b2_reg);
        xdl = 32'(a_dl_reg);
        xda = 34'(a_da_reg);
        xdb = 34'(a_db_reg);
        tl_full = xdl * xdl;
        // textiles: kL = 2 divides the lightness term by four
        b_tl_next = (a_mode_reg == MODE_TEXTILE) ? (unsigned'(tl_full) >> 2)
                                                 : unsigned'(tl_full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else if (en)
            b_vld_reg <= a_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_mode_reg <= a_mode_reg;
            b_sq1_reg  <= unsigned'(xa1 * xa1) + unsigned'(xb1 * xb1);
            b_sq2_reg  <= unsigned'(xa2 * xa2) + unsigned'(xb2 * xb2);
            b_dab_reg  <= unsigned'(xda * xda) + unsigned'(xdb * xdb);
            b_tl_reg   <= b_tl_next;
        end
    end

    // ---- Chroma roots: both colors side by side, 32 stages ----
    typedef struct packed {
        app_mode_t   mode;
        logic [33:0] dab;
        logic [31:0] tl;
    } chroma_pay_t;

    chroma_pay_t                       ch_pay_in, ch_pay_out;
    logic [1:0][RAD_W-1:0]             ch_rad;
    logic [1:0][CH_W-1:0]              ch_root;
    logic                              ch_vld;

    assign ch_pay_in = '{mode: b_mode_reg, dab: b_dab_reg, tl: b_tl_reg};
    assign ch_rad[0] = {b_sq1_reg, 32'd0};
    assign ch_rad[1] = {b_sq2_reg, 32'd0};

    cie94_sqrt_pipe #(
        .W     (RAD_W),
        .LANES (2),
        .PW    ($bits(chroma_pay_t))
    ) u_chroma (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (b_vld_reg),
        .in_rad    (ch_rad),
        .in_pay    (ch_pay_in),
        .out_valid (ch_vld),
        .out_root  (ch_root),
        .out_rem   (),
        .out_pay   (ch_pay_out)
    );

    // ---- Stage C: chroma difference and weight products ----
    logic                c_vld_reg;
    logic [CH_W-1:0]     c_dcm_reg;
    logic [K_W+CH_W-1:0] c_p1_reg, c_p2_reg;
    logic [33:0]         c_dab_reg;
    logic [31:0]         c_tl_reg;
    logic [K_W-1:0]      k1, k2;

    always_comb
    begin
        k1 = (ch_pay_out.mode == MODE_TEXTILE) ? K1_TEXTILE : K1_GRAPHIC;
        k2 = (ch_pay_out.mode == MODE_TEXTILE) ? K2_TEXTILE : K2_GRAPHIC;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_vld_reg <= 1'b0;
        else if (en)
            c_vld_reg <= ch_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_dcm_reg <= (ch_root[0] >= ch_root[1]) ? ch_root[0] - ch_root[1]
                                                    : ch_root[1] - ch_root[0];
            c_p1_reg  <= (K_W+CH_W)'(k1) * (K_W+CH_W)'(ch_root[0]);
            c_p2_reg  <= (K_W+CH_W)'(k2) * (K_W+CH_W)'(ch_root[0]);
            c_dab_reg <= ch_pay_out.dab;
            c_tl_reg  <= ch_pay_out.tl;
        end
    end

    // ---- Stage D: dC squared, SC and SH ----
    logic              d_vld_reg;
    logic [NUM_W-1:0]  d_dcsq_reg;
    logic [WT_W-1:0]   d_sc_reg, d_sh_reg;
    logic [33:0]       d_dab_reg;
    logic [31:0]       d_tl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_vld_reg <= 1'b0;
        else if (en)
            d_vld_reg <= c_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_dcsq_reg <= NUM_W'(c_dcm_reg) * NUM_W'(c_dcm_reg);
            d_sc_reg   <= WEIGHT_ONE + WT_W'(c_p1_reg >> (FRAC_BITS + CHROMA_EXTRA));
            d_sh_reg   <= WEIGHT_ONE + WT_W'(c_p2_reg >> (FRAC_BITS + CHROMA_EXTRA));
            d_dab_reg  <= c_dab_reg;
            d_tl_reg   <= c_tl_reg;
        end
    end

    // ---- Stage E: squared hue difference, divider numerators ----
    logic              e_vld_reg;
    logic [NUM_W-1:0]  e_nc_reg, e_nh_reg;
    logic [WT_W-1:0]   e_sc_reg, e_sh_reg;
    logic [31:0]       e_tl_reg;
    logic [NUM_W-1:0]  dc_round;
    logic [33:0]       dc2, dh2;

    always_comb
    begin
        // dC^2 back in raw units, rounded
        dc_round = d_dcsq_reg + NUM_W'(64'h8000_0000);
        dc2      = 34'(dc_round[63:32]);
        dh2      = (d_dab_reg > dc2) ? d_dab_reg - dc2 : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_vld_reg <= 1'b0;
        else if (en)
            e_vld_reg <= d_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_nc_reg <= d_dcsq_reg;
            e_nh_reg <= {14'd0, dh2, 16'd0};
            e_sc_reg <= d_sc_reg;
            e_sh_reg <= d_sh_reg;
            e_tl_reg <= d_tl_reg;
        end
    end

    // ---- First division: dC^2/SC and dH^2*2^16/SH ----
    logic                    q1_vld;
    logic [1:0][QUO_W-1:0]   q1_quo;
    logic [1:0][WT_W-1:0]    q1_den;
    logic [31:0]             q1_tl;

    cie94_div_pipe #(
        .NW    (NUM_W),
        .DW    (WT_W),
        .Q     (QUO_W),
        .LANES (2),
        .PW    (32)
    ) u_div_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (e_vld_reg),
        .in_num    ({e_nh_reg, e_nc_reg}),
        .in_den    ({e_sh_reg, e_sc_reg}),
        .in_pay    (e_tl_reg),
        .out_valid (q1_vld),
        .out_quo   (q1_quo),
        .out_den   (q1_den),
        .out_pay   (q1_tl)
    );

    // ---- Second division by the same weights ----
    logic                    q2_vld;
    logic [1:0][QUO_W-1:0]   q2_quo;
    logic [1:0][NUM_W-1:0]   q2_num;
    logic [31:0]             q2_tl;

    assign q2_num[0] = NUM_W'(q1_quo[0]);
    assign q2_num[1] = {q1_quo[1], 16'd0};

    cie94_div_pipe #(
        .NW    (NUM_W),
        .DW    (WT_W),
        .Q     (QUO_W),
        .LANES (2),
        .PW    (32)
    ) u_div_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (q1_vld),
        .in_num    (q2_num),
        .in_den    (q1_den),
        .in_pay    (q1_tl),
        .out_valid (q2_vld),
        .out_quo   (q2_quo),
        .out_den   (),
        .out_pay   (q2_tl)
    );

    // ---- Stage F: sum of the three terms ----
    logic             f_vld_reg;
    logic [SUM_W-1:0] f_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_vld_reg <= 1'b0;
        else if (en)
            f_vld_reg <= q2_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            f_sum_reg <= SUM_W'(q2_tl) + SUM_W'(q2_quo[0]) + SUM_W'(q2_quo[1]);
    end

    // ---- Final root, 19 stages ----
    localparam int RT_W = SUM_W / 2;
    logic                   rt_vld;
    logic [0:0][RT_W-1:0]   rt_root;
    logic [0:0][RT_W:0]     rt_rem;

    cie94_sqrt_pipe #(
        .W     (SUM_W),
        .LANES (1),
        .PW    (1)
    ) u_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_vld_reg),
        .in_rad    (f_sum_reg),
        .in_pay    (1'b0),
        .out_valid (rt_vld),
        .out_root  (rt_root),
        .out_rem   (rt_rem),
        .out_pay   ()
    );

    // ---- Output register: round half up and saturate ----
    logic [OUT_W-1:0] out_de_reg;
    logic             out_sat_reg;
    logic [RT_W:0]    rnd;

    // sum > r^2 + r  <=>  remainder > r
    assign rnd = (RT_W+1)'(rt_root[0]) + (RT_W+1)'(rt_rem[0] > (RT_W+1)'(rt_root[0]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= rt_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_sat_reg <= (rnd > (RT_W+1)'({OUT_W{1'b1}}));
            out_de_reg  <= (rnd > (RT_W+1)'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : rnd[OUT_W-1:0];
        end
    end

    assign result.valid     = out_vld_reg;
    assign result.delta_e   = out_de_reg;
    assign result.saturated = out_sat_reg;

    // ---- Checks ----
    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.saturated |-> result.delta_e == {OUT_W{1'b1}})
        else $error("saturated result not at maximum");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        pair.valid && pair.ready |=> a_vld_reg)
        else $error("transferred pair did not enter the pipeline");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(a_vld_reg) && $stable(f_vld_reg))
        else $error("pipeline moved during a stall");

    a_hue_align: assert property (@(posedge clk) disable iff (!rst_n)
        e_vld_reg |-> e_nh_reg[15:0] == 16'd0)
        else $error("hue numerator misaligned");

endmodule
`default_nettype wire
